@@ src/tsrp_pkg.sv @@
// Package for the tape speed ramp position core: widths, operation codes,
// register indexes, reset values and the controller/datapath command structs.
// No dependencies; every other file of the block refers to it by scoped names.
package tsrp_pkg;

  // Field widths.
  localparam int unsigned OP_W     = 3;
  localparam int unsigned DT_W     = 32;
  localparam int unsigned POS_W    = 40;
  localparam int unsigned VEL_W    = 24;
  localparam int unsigned DIV_W    = 16;
  localparam int unsigned MAG_W    = 24;
  localparam int unsigned NUM_W    = MAG_W + DIV_W;
  localparam int unsigned DEN_W    = DT_W + DIV_W;
  localparam int unsigned DVD_W    = 64;
  localparam int unsigned QUO_W    = 27;
  localparam int unsigned DS_W     = DEN_W + QUO_W - 1;
  localparam int unsigned OVF_W    = DEN_W + QUO_W;
  localparam int unsigned STEP_W   = POS_W;
  localparam int unsigned PSUM_W   = POS_W + 2;
  localparam int unsigned VSUM_W   = QUO_W + 1;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned DIV_STEPS = QUO_W;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_DIV = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECEL_MULT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_LEN = 2'd2;

  localparam logic [DIV_W-1:0] WEIGHT_DIV_RST = 16'd200;
  localparam logic [DIV_W-1:0] DECEL_MULT_RST = 16'd461;
  localparam logic [POS_W-1:0] SAMPLE_LEN_RST = 40'd2890137600;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
  localparam logic [OP_W-1:0] OP_START   = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP    = 3'd2;
  localparam logic [OP_W-1:0] OP_SET_POS = 3'd3;
  localparam logic [OP_W-1:0] OP_SET_VEL = 3'd4;

  // Arithmetic constants.
  localparam logic signed [VEL_W:0]    ONE_Q16   = 25'sd65536;
  localparam logic [QUO_W-1:0]         DELTA_CAP = 27'd67108864;
  localparam logic signed [VSUM_W-1:0] VEL_MAX_S = 28'sd8388607;
  localparam logic signed [VSUM_W-1:0] VEL_MIN_S = -28'sd8388608;
  localparam logic signed [PSUM_W-1:0] POS_MAX_S = 42'sd549755813887;
  localparam logic signed [PSUM_W-1:0] POS_MIN_S = -42'sd549755813888;
  localparam logic signed [POS_W-1:0]  VEL_MAX_P = 40'sd8388607;
  localparam logic signed [POS_W-1:0]  VEL_MIN_P = -40'sd8388608;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic prep;
    logic setup;
    logic div_step;
    logic vel;
    logic pmul;
    logic padd;
    logic wrap;
    logic commit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tick_go;
  } dp_status_t;

endpackage

@@ src/tsrp_in_if.sv @@
// Input channel interface of the tape speed ramp position core.
// Depends on tsrp_pkg for field widths.
interface tsrp_in_if;
  logic                               valid;
  logic                               ready;
  logic [tsrp_pkg::OP_W-1:0]          operation;
  logic [tsrp_pkg::DT_W-1:0]          time_step;
  logic signed [tsrp_pkg::POS_W-1:0]  new_value;

  modport source (output valid, output operation, output time_step, output new_value,
                  input ready);
  modport sink (input valid, input operation, input time_step, input new_value,
                output ready);
endinterface

@@ src/tsrp_out_if.sv @@
// Result channel interface of the tape speed ramp position core.
// Depends on tsrp_pkg for field widths.
interface tsrp_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [tsrp_pkg::POS_W-1:0]  position;
  logic signed [tsrp_pkg::VEL_W-1:0]  velocity;
  logic                               is_playing;

  modport source (output valid, output position, output velocity, output is_playing,
                  input ready);
  modport sink (input valid, input position, input velocity, input is_playing,
                output ready);
endinterface

@@ src/tsrp_ctrl.sv @@
// Controller of the tape speed ramp position core: one-hot sequencer, divider
// step counter and result valid flag. Depends on tsrp_pkg.
module tsrp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  tsrp_pkg::dp_status_t status_i,
  output tsrp_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PREP  = 9'b000000010,
    S_SETUP = 9'b000000100,
    S_DIV   = 9'b000001000,
    S_VEL   = 9'b000010000,
    S_PMUL  = 9'b000100000,
    S_PADD  = 9'b001000000,
    S_WRAP  = 9'b010000000,
    S_WB    = 9'b100000000
  } state_e;

  localparam logic [tsrp_pkg::CNT_W-1:0] DIV_LAST =
    tsrp_pkg::CNT_W'(tsrp_pkg::DIV_STEPS - 1);

  state_e                      state_q, state_d;
  logic [tsrp_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                        out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = status_i.tick_go ? S_PREP : S_WB;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_SETUP;
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        cnt_d       = DIV_LAST;
        state_d     = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_VEL;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_VEL: begin
        cmd_o.vel = 1'b1;
        state_d   = S_PMUL;
      end
      S_PMUL: begin
        cmd_o.pmul = 1'b1;
        state_d    = S_PADD;
      end
      S_PADD: begin
        cmd_o.padd = 1'b1;
        state_d    = S_WRAP;
      end
      S_WRAP: begin
        cmd_o.wrap = 1'b1;
        state_d    = S_WB;
      end
      S_WB: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_commit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || out_ready_i))
    else $error("result committed over an untaken result");

  a_tick_enters_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && status_i.tick_go) |=> (state_q == S_PREP))
    else $error("tick did not start the arithmetic sequence");

  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q == '0) |=> (state_q == S_VEL))
    else $error("divider did not hand over after its last step");
`endif

endmodule

@@ src/tsrp_dp.sv @@
// Datapath of the tape speed ramp position core: configuration registers,
// playback state, multipliers, restoring divider and position update.
// Depends on tsrp_pkg; driven by the command struct from tsrp_ctrl.
module tsrp_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [tsrp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [tsrp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic [tsrp_pkg::OP_W-1:0]            operation_i,
  input  logic [tsrp_pkg::DT_W-1:0]            time_step_i,
  input  logic signed [tsrp_pkg::POS_W-1:0]    new_value_i,
  input  tsrp_pkg::dp_cmd_t                    cmd_i,
  output tsrp_pkg::dp_status_t                 status_o,
  output logic signed [tsrp_pkg::POS_W-1:0]    position_o,
  output logic signed [tsrp_pkg::VEL_W-1:0]    velocity_o,
  output logic                                 is_playing_o
);

  // Configuration registers.
  logic [tsrp_pkg::DIV_W-1:0] wdiv_q;
  logic [tsrp_pkg::DIV_W-1:0] decel_q;
  logic [tsrp_pkg::POS_W-1:0] slen_q;

  // Playback state.
  logic signed [tsrp_pkg::POS_W-1:0] pos_q, pos_d;
  logic signed [tsrp_pkg::VEL_W-1:0] vel_q, vel_d;
  logic                              playing_q, playing_d;

  // Latched transaction.
  logic [tsrp_pkg::OP_W-1:0]         op_q;
  logic [tsrp_pkg::DT_W-1:0]         dt_q;
  logic signed [tsrp_pkg::POS_W-1:0] nv_q;
  logic                              tick_q;

  // Tick working registers.
  logic                              neg_q;
  logic                              mag_zero_q;
  logic [tsrp_pkg::NUM_W-1:0]        num_q;
  logic [tsrp_pkg::DEN_W-1:0]        den_q;
  logic [tsrp_pkg::DVD_W-1:0]        rem_q;
  logic [tsrp_pkg::DS_W-1:0]         ds_q;
  logic                              ovf_q;
  logic [tsrp_pkg::QUO_W-1:0]        quo_q;
  logic signed [tsrp_pkg::VEL_W-1:0] vel_new_q;
  logic [tsrp_pkg::STEP_W-1:0]       step_q;
  logic signed [tsrp_pkg::POS_W-1:0] pos_sat_q;
  logic signed [tsrp_pkg::POS_W-1:0] pos_new_q;

  logic signed [tsrp_pkg::VEL_W:0]    target_s;
  logic signed [tsrp_pkg::VEL_W:0]    diff_s;
  logic [tsrp_pkg::MAG_W-1:0]         mag;
  logic [tsrp_pkg::DIV_W-1:0]         div_eff;
  logic [tsrp_pkg::DVD_W-1:0]         dividend;
  logic                               rem_ge;
  logic [tsrp_pkg::QUO_W-1:0]         qsat;
  logic signed [tsrp_pkg::VSUM_W-1:0] vsum;
  logic [tsrp_pkg::MAG_W-1:0]         vmag;
  logic [tsrp_pkg::DVD_W-1:0]         pprod;
  logic signed [tsrp_pkg::PSUM_W-1:0] psum;
  logic signed [tsrp_pkg::PSUM_W-1:0] step_s;
  logic signed [tsrp_pkg::POS_W:0]    wrap_diff;
  logic                               wrap_hit;

  assign status_o.tick_go = (operation_i == tsrp_pkg::OP_TICK) && (time_step_i != '0);

  // Velocity error and its magnitude.
  always_comb begin
    target_s = playing_q ? tsrp_pkg::ONE_Q16 : '0;
    diff_s   = target_s - {vel_q[tsrp_pkg::VEL_W-1], vel_q};
    mag      = diff_s[tsrp_pkg::VEL_W] ? tsrp_pkg::MAG_W'(-diff_s)
                                       : tsrp_pkg::MAG_W'(diff_s);
    div_eff  = (wdiv_q == '0) ? tsrp_pkg::DIV_W'(1) : wdiv_q;
  end

  // The stopped weight carries eight more fraction bits from the Q8.8 factor.
  assign dividend = playing_q ? {8'b0, num_q, 16'b0} : {num_q, 24'b0};

  assign rem_ge = ({10'b0, rem_q} >= ds_q);

  // Capped correction, then the saturated velocity sum.
  always_comb begin
    if (mag_zero_q) begin
      qsat = '0;
    end else if (ovf_q || (quo_q > tsrp_pkg::DELTA_CAP)) begin
      qsat = tsrp_pkg::DELTA_CAP;
    end else begin
      qsat = quo_q;
    end
    vsum = neg_q ? ({{4{vel_q[tsrp_pkg::VEL_W-1]}}, vel_q} - $signed({1'b0, qsat}))
                 : ({{4{vel_q[tsrp_pkg::VEL_W-1]}}, vel_q} + $signed({1'b0, qsat}));
  end

  always_comb begin
    vmag  = vel_new_q[tsrp_pkg::VEL_W-1] ? tsrp_pkg::MAG_W'(-vel_new_q)
                                         : tsrp_pkg::MAG_W'(vel_new_q);
    pprod = {40'b0, vmag} * {32'b0, dt_q};
  end

  always_comb begin
    step_s    = vel_new_q[tsrp_pkg::VEL_W-1] ? -$signed({2'b0, step_q})
                                             : $signed({2'b0, step_q});
    psum      = {{2{pos_q[tsrp_pkg::POS_W-1]}}, pos_q} + step_s;
    wrap_hit  = $signed({pos_sat_q[tsrp_pkg::POS_W-1], pos_sat_q}) >
                $signed({1'b0, slen_q});
    wrap_diff = {pos_sat_q[tsrp_pkg::POS_W-1], pos_sat_q} - $signed({1'b0, slen_q});
  end

  // Next playback state at commit.
  always_comb begin
    pos_d     = pos_q;
    vel_d     = vel_q;
    playing_d = playing_q;
    if (tick_q) begin
      pos_d = pos_new_q;
      vel_d = vel_new_q;
    end else begin
      unique case (op_q)
        tsrp_pkg::OP_START:   playing_d = 1'b1;
        tsrp_pkg::OP_STOP:    playing_d = 1'b0;
        tsrp_pkg::OP_SET_POS: pos_d = nv_q;
        tsrp_pkg::OP_SET_VEL: begin
          if (nv_q > tsrp_pkg::VEL_MAX_P) begin
            vel_d = tsrp_pkg::VEL_W'(tsrp_pkg::VEL_MAX_P);
          end else if (nv_q < tsrp_pkg::VEL_MIN_P) begin
            vel_d = tsrp_pkg::VEL_W'(tsrp_pkg::VEL_MIN_P);
          end else begin
            vel_d = nv_q[tsrp_pkg::VEL_W-1:0];
          end
        end
        default: begin
          playing_d = playing_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wdiv_q    <= tsrp_pkg::WEIGHT_DIV_RST;
      decel_q   <= tsrp_pkg::DECEL_MULT_RST;
      slen_q    <= tsrp_pkg::SAMPLE_LEN_RST;
      pos_q     <= '0;
      vel_q     <= '0;
      playing_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tsrp_pkg::CFG_WEIGHT_DIV: wdiv_q  <= cfg_data_i[tsrp_pkg::DIV_W-1:0];
          tsrp_pkg::CFG_DECEL_MULT: decel_q <= cfg_data_i[tsrp_pkg::DIV_W-1:0];
          tsrp_pkg::CFG_SAMPLE_LEN: slen_q  <= cfg_data_i[tsrp_pkg::POS_W-1:0];
          default: begin
            slen_q <= slen_q;
          end
        endcase
      end
      if (cmd_i.commit) begin
        pos_q     <= pos_d;
        vel_q     <= vel_d;
        playing_q <= playing_d;
      end
    end
  end

  // Working registers hold payload only and need no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q   <= operation_i;
      dt_q   <= time_step_i;
      nv_q   <= new_value_i;
      tick_q <= status_o.tick_go;
    end
    if (cmd_i.prep) begin
      neg_q      <= diff_s[tsrp_pkg::VEL_W];
      mag_zero_q <= (mag == '0);
      num_q      <= tsrp_pkg::NUM_W'({24'b0, mag} * {24'b0, div_eff});
      den_q      <= playing_q ? {16'b0, dt_q}
                              : tsrp_pkg::DEN_W'({16'b0, dt_q} * {32'b0, decel_q});
    end
    if (cmd_i.setup) begin
      rem_q <= dividend;
      ds_q  <= {den_q, 26'b0};
      ovf_q <= ({11'b0, dividend} >= {den_q, 27'b0});
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (rem_ge) begin
        rem_q <= rem_q - ds_q[tsrp_pkg::DVD_W-1:0];
      end
      quo_q <= {quo_q[tsrp_pkg::QUO_W-2:0], rem_ge};
      ds_q  <= ds_q >> 1;
    end
    if (cmd_i.vel) begin
      if (vsum > tsrp_pkg::VEL_MAX_S) begin
        vel_new_q <= tsrp_pkg::VEL_W'(tsrp_pkg::VEL_MAX_S);
      end else if (vsum < tsrp_pkg::VEL_MIN_S) begin
        vel_new_q <= tsrp_pkg::VEL_W'(tsrp_pkg::VEL_MIN_S);
      end else begin
        vel_new_q <= vsum[tsrp_pkg::VEL_W-1:0];
      end
    end
    if (cmd_i.pmul) begin
      step_q <= pprod[tsrp_pkg::STEP_W+15:16];
    end
    if (cmd_i.padd) begin
      if (psum > tsrp_pkg::POS_MAX_S) begin
        pos_sat_q <= tsrp_pkg::POS_W'(tsrp_pkg::POS_MAX_S);
      end else if (psum < tsrp_pkg::POS_MIN_S) begin
        pos_sat_q <= tsrp_pkg::POS_W'(tsrp_pkg::POS_MIN_S);
      end else begin
        pos_sat_q <= psum[tsrp_pkg::POS_W-1:0];
      end
    end
    if (cmd_i.wrap) begin
      pos_new_q <= wrap_hit ? wrap_diff[tsrp_pkg::POS_W-1:0] : pos_sat_q;
    end
  end

  assign position_o   = pos_q;
  assign velocity_o   = vel_q;
  assign is_playing_o = playing_q;

`ifndef SYNTHESIS
  a_set_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && !tick_q && op_q == tsrp_pkg::OP_SET_POS) |=> (pos_q == $past(nv_q)))
    else $error("set position did not land in the position register");

  a_zero_error_keeps_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.vel && mag_zero_q) |=> (vel_new_q == $past(vel_q)))
    else $error("velocity moved although it already matched the target");

  a_play_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(playing_q) |-> ($past(op_q) == tsrp_pkg::OP_START && !$past(tick_q)))
    else $error("playing flag set by something other than a start");
`endif

endmodule

@@ src/tape_speed_ramp_position_core.sv @@
// Top level of the tape speed ramp position core.
// Depends on tsrp_pkg, tsrp_in_if, tsrp_out_if, tsrp_ctrl and tsrp_dp.
//
//   Channel  Direction  Handshake       Payload
//   in_i     sink       valid / ready   operation, time_step, new_value
//   out_o    source     valid / ready   position, velocity, is_playing
//   cfg      write      cfg_we_i        cfg_idx_i, cfg_data_i
//
// A tick with a nonzero time step runs the 27-step restoring divider for the
// velocity correction, then the position update, between acceptance and commit.
// Every other operation is accepted and then committed, with no arithmetic between.
// Reset is asynchronous and active low; it clears the playback state and loads
// the register defaults, and no memory needs a clearing pass.
// A result that waits on out_o holds only the final commit: the next
// transaction is still accepted and worked on, and commits once out_o is free.
module tape_speed_ramp_position_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tsrp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tsrp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  tsrp_in_if.sink                            in_i,
  tsrp_out_if.source                         out_o
);

  // Commands and status between the sequencer and the arithmetic.
  tsrp_pkg::dp_cmd_t    cmd;
  tsrp_pkg::dp_status_t status;

  // The sequencer owns the handshakes and the divider step count. It only
  // accepts a transaction in its idle state, and it raises the result valid
  // flag on the cycle the datapath commits the new playback state.
  tsrp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath keeps the playback state, which is also the result payload:
  // it changes only at a commit, and a commit never overwrites an untaken
  // result, so the payload holds steady while out_o is stalled.
  tsrp_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .operation_i  (in_i.operation),
    .time_step_i  (in_i.time_step),
    .new_value_i  (in_i.new_value),
    .cmd_i        (cmd),
    .status_o     (status),
    .position_o   (out_o.position),
    .velocity_o   (out_o.velocity),
    .is_playing_o (out_o.is_playing)
  );

endmodule
